@@ design/ils_pkg.sv @@
// ils_pkg: shared types and codes for the indexed list store
// holds the command and status codes and the transaction payload structs
// no dependencies
package ils_pkg;

    // field widths of the transactions
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // default number of slots
    localparam int CAPACITY_DEF = 64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TAIL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // value reported when nothing was read
    localparam logic signed [VALUE_W-1:0] NO_VALUE = -32'sd1;

    // request transaction
    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] new_value;
    } list_req_t;

    // response transaction
    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
    } list_rsp_t;

endpackage

@@ design/ils_ram.sv @@
// ils_ram: generic simple dual-port ram, one write and one registered read port
// used for the slot values and the slot links of the indexed list store
// no dependencies
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/indexed_list_store.sv @@
// indexed_list_store: ordered list of signed values kept as a linked list in slot memories
// one command per transaction; walks the link ram one slot per cycle. one command at a time:
// req_stall holds off a new request until the response of the last one has been handed
// to the response register. after reset a pass over every slot rebuilds the free chain
// in the link ram before the first request.
module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  list_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output list_rsp_t rsp
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CAPACITY);

    typedef enum logic [13:0] {
        S_INIT = 14'b00000000000001,
        S_IDLE = 14'b00000000000010,
        S_WALK = 14'b00000000000100,
        S_GDAT = 14'b00000000001000,
        S_INSA = 14'b00000000010000,
        S_INSB = 14'b00000000100000,
        S_INSC = 14'b00000001000000,
        S_INSD = 14'b00000010000000,
        S_DEL0 = 14'b00000100000000,
        S_DEL1 = 14'b00001000000000,
        S_DELA = 14'b00010000000000,
        S_DELB = 14'b00100000000000,
        S_DELC = 14'b01000000000000,
        S_FIN  = 14'b10000000000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [SLOT_W-1:0]         first_reg, first_next;
    logic [SLOT_W-1:0]         free_reg, free_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [SLOT_W-1:0]         cur_reg, cur_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [CNT_W-1:0]          steps_reg, steps_next;
    logic                      pend_reg, pend_next;
    logic [CMD_W-1:0]          cmd_reg, cmd_next;
    logic [SLOT_W-1:0]         idx_reg, idx_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic signed [VALUE_W-1:0] rdv_reg, rdv_next;
    logic [STATUS_W-1:0]       st_reg, st_next;
    list_rsp_t                 rsp_reg, rsp_next;

    // ram ports
    logic                      lk_we;
    logic [SLOT_W-1:0]         lk_waddr, lk_wdata, lk_raddr, lk_rdata;
    logic                      en_we;
    logic [SLOT_W-1:0]         en_waddr, en_raddr;
    logic [VALUE_W-1:0]        en_wdata, en_rdata;

    logic                      accept;
    logic [CMP_W-1:0]          pos_ext, cnt_ext, ins_pos;
    logic [SLOT_W-1:0]         walk_cur;

    ils_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_links (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    ils_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (en_we),
        .waddr (en_waddr),
        .wdata (en_wdata),
        .raddr (en_raddr),
        .rdata (en_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign pos_ext  = CMP_W'(req.position);
    assign cnt_ext  = CMP_W'(count_reg);
    // walk pointer: follow the link read last cycle if one is pending
    assign walk_cur = pend_reg ? lk_rdata : cur_reg;

    // insert position after folding the head and tail forms
    always_comb
    begin
        case (req.command)
            CMD_HEAD: ins_pos = '0;
            CMD_TAIL: ins_pos = cnt_ext;
            default:  ins_pos = pos_ext;
        endcase
    end

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        slot_next      = slot_reg;
        steps_next     = steps_reg;
        pend_next      = pend_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        rdv_next       = rdv_reg;
        st_next        = st_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        lk_we    = 1'b0;
        lk_waddr = cur_reg;
        lk_wdata = slot_reg;
        lk_raddr = cur_reg;
        en_we    = 1'b0;
        en_waddr = free_reg;
        en_wdata = val_reg;
        en_raddr = cur_reg;

        // response register drains when taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            // rebuild the free chain 0, 1, ..., last -> 0
            S_INIT:
            begin
                lk_we    = 1'b1;
                lk_waddr = idx_reg;
                lk_wdata = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end

            // decode and range check a new transaction
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next  = req.new_value;
                    rdv_next  = NO_VALUE;
                    st_next   = ST_DONE;
                    cmd_next  = req.command;
                    cur_next  = first_reg;
                    pend_next = 1'b0;
                    case (req.command)
                        CMD_GET:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                steps_next = CNT_W'(req.position);
                                state_next = S_WALK;
                            end
                            else
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_FIN;
                            end
                        end
                        CMD_INSERT, CMD_HEAD, CMD_TAIL:
                        begin
                            cmd_next = CMD_INSERT;
                            if (ins_pos > cnt_ext)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_FIN;
                            end
                            else if (count_reg == FULL_CNT)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                steps_next = CNT_W'(ins_pos);
                                state_next = S_INSA;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_FIN;
                            end
                            else if (req.position == '0)
                            begin
                                state_next = S_DEL0;
                            end
                            else
                            begin
                                steps_next = CNT_W'(req.position) - 1'b1;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // follow links one slot per cycle
            S_WALK:
            begin
                if (steps_reg == '0)
                begin
                    cur_next  = walk_cur;
                    pend_next = 1'b0;
                    if (cmd_reg == CMD_GET)
                    begin
                        en_raddr   = walk_cur;
                        state_next = S_GDAT;
                    end
                    else
                    begin
                        lk_raddr   = walk_cur;
                        state_next = (cmd_reg == CMD_DELETE) ? S_DELA : S_INSC;
                    end
                end
                else
                begin
                    lk_raddr   = walk_cur;
                    cur_next   = walk_cur;
                    pend_next  = 1'b1;
                    steps_next = steps_reg - 1'b1;
                end
            end

            // value of the target slot is out of the ram
            S_GDAT:
            begin
                rdv_next   = en_rdata;
                state_next = S_FIN;
            end

            // take the free head slot and store the value
            S_INSA:
            begin
                lk_raddr   = free_reg;
                en_we      = 1'b1;
                en_waddr   = free_reg;
                en_wdata   = val_reg;
                slot_next  = free_reg;
                state_next = S_INSB;
            end

            // pop the free chain, link in at the head or walk to the predecessor
            S_INSB:
            begin
                free_next = lk_rdata;
                if (steps_reg == '0)
                begin
                    lk_we      = 1'b1;
                    lk_waddr   = slot_reg;
                    lk_wdata   = first_reg;
                    first_next = slot_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cur_next   = first_reg;
                    pend_next  = 1'b0;
                    steps_next = steps_reg - 1'b1;
                    state_next = S_WALK;
                end
            end

            // new slot points at the predecessor's successor
            S_INSC:
            begin
                lk_we      = 1'b1;
                lk_waddr   = slot_reg;
                lk_wdata   = lk_rdata;
                state_next = S_INSD;
            end

            // predecessor points at the new slot
            S_INSD:
            begin
                lk_we      = 1'b1;
                lk_waddr   = cur_reg;
                lk_wdata   = slot_reg;
                count_next = count_reg + 1'b1;
                state_next = S_FIN;
            end

            // delete at the head: fetch the successor of the first slot
            S_DEL0:
            begin
                lk_raddr   = first_reg;
                slot_next  = first_reg;
                state_next = S_DEL1;
            end

            S_DEL1:
            begin
                first_next = lk_rdata;
                state_next = S_DELC;
            end

            // victim is the predecessor's successor; fetch its successor
            S_DELA:
            begin
                slot_next  = lk_rdata;
                lk_raddr   = lk_rdata;
                state_next = S_DELB;
            end

            // unlink the victim
            S_DELB:
            begin
                lk_we      = 1'b1;
                lk_waddr   = cur_reg;
                lk_wdata   = lk_rdata;
                state_next = S_DELC;
            end

            // push the victim on the free chain
            S_DELC:
            begin
                lk_we      = 1'b1;
                lk_waddr   = slot_reg;
                lk_wdata   = free_reg;
                free_next  = slot_reg;
                count_next = count_reg - 1'b1;
                state_next = S_FIN;
            end

            // hand the result to the response register once it is free
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.read_value = rdv_reg;
                    rsp_next.status     = st_reg;
                    rsp_next.count      = COUNT_W'(count_reg);
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            first_reg     <= '0;
            free_reg      <= '0;
            count_reg     <= '0;
            cur_reg       <= '0;
            slot_reg      <= '0;
            steps_reg     <= '0;
            pend_reg      <= 1'b0;
            cmd_reg       <= CMD_GET;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            slot_reg      <= slot_next;
            steps_reg     <= steps_next;
            pend_reg      <= pend_next;
            cmd_reg       <= cmd_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rdv_reg <= rdv_next;
        st_reg  <= st_next;
        rsp_reg <= rsp_next;
    end

endmodule
